@@ rtl/memory_map_access_decoder_top_assert.svh @@
// assertion macros for the memory map access decoder
// used by memory_map_access_decoder_top; no other dependencies
`ifndef MEMORY_MAP_ACCESS_DECODER_TOP_ASSERT_SVH
`define MEMORY_MAP_ACCESS_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define MMAD_ASSERT_ALWAYS(lbl, c, rn, expr) \
	lbl: assert property (@(posedge c) disable iff (!(rn)) (expr)) \
		else $error("mmad assertion failed");

// consequent holds in the same cycle as the antecedent
`define MMAD_ASSERT_IMPLY(lbl, c, rn, ante, cons) \
	lbl: assert property (@(posedge c) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("mmad assertion failed");

// consequent holds in the cycle after the antecedent
`define MMAD_ASSERT_NEXT(lbl, c, rn, ante, cons) \
	lbl: assert property (@(posedge c) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("mmad assertion failed");

`else

`define MMAD_ASSERT_ALWAYS(lbl, c, rn, expr)
`define MMAD_ASSERT_IMPLY(lbl, c, rn, ante, cons)
`define MMAD_ASSERT_NEXT(lbl, c, rn, ante, cons)

`endif

`endif

@@ rtl/mmad_pkg.sv @@
// shared types, constants and address decode functions for the access decoder
// no dependencies
`timescale 1ns / 1ps

package mmad_pkg;

	// field widths
	localparam int unsigned ADDR_W   = 16;
	localparam int unsigned DATA_W   = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned ROUTE_W  = 2;
	localparam int unsigned CTL_W    = 16;
	localparam int unsigned CTL_IDX_W = 4;

	// memory is split into even and odd byte banks
	localparam int unsigned BANK_DEPTH = 32768;
	localparam int unsigned BANK_AW    = 15;

	// kind bits
	localparam int unsigned KIND_WRITE_BIT = 0;
	localparam int unsigned KIND_WORD_BIT  = 1;

	// control bit that disables the mirror fold
	localparam int unsigned MODE_BIT = 15;

	// address map
	localparam logic [ADDR_W-1:0] MEM_TOP   = 16'hFEFF;
	localparam logic [ADDR_W-1:0] PER0_TOP  = 16'hFF03;
	localparam logic [ADDR_W-1:0] DED0_TOP  = 16'hFF1F;
	localparam logic [ADDR_W-1:0] PER1_TOP  = 16'hFF23;
	localparam logic [ADDR_W-1:0] DED1_TOP  = 16'hFFBF;
	localparam logic [ADDR_W-1:0] CTL_TOP   = 16'hFFDF;
	localparam logic [ADDR_W-1:0] VEC_BASE  = 16'hFFF2;
	localparam logic [ADDR_W-1:0] VEC_SHIFT = 16'h4000;
	localparam logic [BYTE_W-1:0] PAGE_HI   = 8'hFF;

	typedef enum logic [1:0] {
		REGION_MEM = 2'd0,
		REGION_PER = 2'd1,
		REGION_CTL = 2'd2,
		REGION_DED = 2'd3
	} region_t;

	typedef enum logic [ROUTE_W-1:0] {
		ROUTE_MEM = 2'd0,
		ROUTE_CTL = 2'd1,
		ROUTE_FWD = 2'd2,
		ROUTE_ERR = 2'd3
	} route_t;

	// how the read data of a transaction is formed
	typedef enum logic [1:0] {
		RSEL_ZERO = 2'd0,
		RSEL_CTL  = 2'd1,
		RSEL_BYTE = 2'd2,
		RSEL_WORD = 2'd3
	} rsel_t;

	// decode result handed from the decoder to the pipeline
	typedef struct packed {
		route_t                route;
		logic [ADDR_W-1:0]     target;
		rsel_t                 rsel;
		logic                  swap;
		logic [BANK_AW-1:0]    even_addr;
		logic [BANK_AW-1:0]    odd_addr;
		logic                  even_we;
		logic                  odd_we;
		logic [BYTE_W-1:0]     even_wdata;
		logic [BYTE_W-1:0]     odd_wdata;
		logic                  ctl_we;
		logic                  ctl_set;
		logic [CTL_IDX_W-1:0]  ctl_idx;
	} mmad_dec_t;

	function automatic region_t region_of(input logic [ADDR_W-1:0] a);
		region_t r;
		if (a <= MEM_TOP)
			r = REGION_MEM;
		else if (a <= PER0_TOP)
			r = REGION_PER;
		else if (a <= DED0_TOP)
			r = REGION_DED;
		else if (a <= PER1_TOP)
			r = REGION_PER;
		else if (a <= DED1_TOP)
			r = REGION_DED;
		else if (a <= CTL_TOP)
			r = REGION_CTL;
		else
			r = REGION_DED;
		return r;
	endfunction

	// mirror fold of an offset within the top page
	function automatic logic [BYTE_W-1:0] fold_offset(input logic [BYTE_W-1:0] off);
		logic [BYTE_W-1:0] r;
		if (off < 8'h20)
			r = {6'b000000, off[1:0]};
		else if (off < 8'h40)
			r = {6'b001000, off[1:0]};
		else if (off < 8'h60) begin
			if (!off[3])
				r = 8'h40;
			else
				r = {6'b010010, off[1:0]};
		end else
			r = off;
		return r;
	endfunction

endpackage

@@ rtl/mmad_ram.sv @@
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mmad_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, or registered read, when enabled
	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem_q[addr] <= wdata;
			else
				rdata <= mem_q[addr];
		end
	end

endmodule

@@ rtl/mmad_decode.sv @@
// address decode, redirection and bank/control write planning for one transaction
// depends on mmad_pkg
`timescale 1ns / 1ps

module mmad_decode (
	input  logic [mmad_pkg::KIND_W-1:0] kind,
	input  logic [mmad_pkg::ADDR_W-1:0] address,
	input  logic [mmad_pkg::DATA_W-1:0] write_data,
	input  logic                        mode,
	output mmad_pkg::mmad_dec_t         dec
);

	import mmad_pkg::*;

	logic              is_write;
	logic              is_word;
	region_t           reg_in;
	region_t           reg_tgt;
	logic [ADDR_W-1:0] tgt;
	logic [ADDR_W-1:0] tgt_next;
	logic              mem_wr;

	assign is_write = kind[KIND_WRITE_BIT];
	assign is_word  = kind[KIND_WORD_BIT];

	// region and redirection of dedicated addresses
	always_comb begin
		reg_in  = region_of(address);
		tgt     = address;
		reg_tgt = reg_in;
		if (reg_in == REGION_DED) begin
			if (address >= VEC_BASE)
				tgt = address - VEC_SHIFT;
			else if (!mode)
				tgt = {PAGE_HI, fold_offset(address[BYTE_W-1:0])};
			reg_tgt = region_of(tgt);
			// a target that is still dedicated (a fold fixed point, or any with mode set) is plain memory
			if (reg_tgt == REGION_DED)
				reg_tgt = REGION_MEM;
		end
	end

	assign tgt_next = tgt + 16'd1;

	// route, read data selection, control and bank write planning
	always_comb begin
		dec.target = tgt;
		dec.rsel   = RSEL_ZERO;
		case (reg_tgt)
			REGION_PER: begin
				dec.route = is_word ? ROUTE_ERR : ROUTE_FWD;
			end
			REGION_CTL: begin
				dec.route = is_word ? ROUTE_ERR : ROUTE_CTL;
				if (!is_word && !is_write)
					dec.rsel = RSEL_CTL;
			end
			default: begin
				dec.route = ROUTE_MEM;
				if (!is_write)
					dec.rsel = is_word ? RSEL_WORD : RSEL_BYTE;
			end
		endcase

		// control bit set/clear by address parity
		dec.ctl_we  = (dec.route == ROUTE_CTL) && is_write;
		dec.ctl_set = tgt[0];
		dec.ctl_idx = tgt[CTL_IDX_W:1];

		// big-endian byte lanes over the even and odd banks
		mem_wr         = (dec.route == ROUTE_MEM) && is_write;
		dec.swap       = tgt[0];
		dec.odd_addr   = tgt[ADDR_W-1:1];
		dec.even_addr  = tgt[0] ? tgt_next[ADDR_W-1:1] : tgt[ADDR_W-1:1];
		dec.even_we    = mem_wr && (is_word || !tgt[0]);
		dec.odd_we     = mem_wr && (is_word || tgt[0]);
		dec.even_wdata = (is_word && !tgt[0]) ? write_data[DATA_W-1:BYTE_W]
			: write_data[BYTE_W-1:0];
		dec.odd_wdata  = (is_word && tgt[0]) ? write_data[DATA_W-1:BYTE_W]
			: write_data[BYTE_W-1:0];
	end

endmodule

@@ rtl/memory_map_access_decoder_top.sv @@
// top level of the memory map access decoder: stream ports, pipeline, banks, control bits
// depends on mmad_pkg, mmad_decode, mmad_ram and memory_map_access_decoder_top_assert.svh
`timescale 1ns / 1ps

// Memory map access decoder. Takes one byte or word read/write per cycle when
// the output is not stalled and returns one result per transaction, in order;
// each passes the input register, the bank access stage and the result
// register. The 64 KiB byte memory is held as an even and an odd bank of
// 32K bytes each, so a big-endian word touches both banks in the same cycle
// and the single-port banks set the rate of one transaction per clock while
// the output is not stalled. Memory contents are not initialized; the 16
// control bits reset to zero. There is no clearing pass after reset.

module memory_map_access_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] address, [31:16] write_data
	input  logic [1:0]  s_axis_tuser,  // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [15:0] read_data, [31:16] target_address
	output logic [1:0]  m_axis_tuser   // [1:0] route
);

	import mmad_pkg::*;

`include "memory_map_access_decoder_top_assert.svh"

	// stage 1: input register
	logic              v_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] wdata_s1;

	// stage 2: after bank access
	logic              v_s2;
	route_t            route_s2;
	logic [ADDR_W-1:0] target_s2;
	rsel_t             rsel_s2;
	logic              swap_s2;
	logic              ctlbit_s2;

	// result register
	logic              v_out_q;
	route_t            route_q;
	logic [ADDR_W-1:0] target_q;
	logic [DATA_W-1:0] rdata_q;

	logic [CTL_W-1:0]  ctl_q;
	mmad_dec_t         dec;
	logic              rdy_out;
	logic              rdy_s2;
	logic              rdy_s1;
	logic              adv1;
	logic [BYTE_W-1:0] even_rd;
	logic [BYTE_W-1:0] odd_rd;
	logic [BYTE_W-1:0] hi_byte;
	logic [BYTE_W-1:0] lo_byte;
	logic [DATA_W-1:0] rdata_s2;

	// stage handshakes
	assign rdy_out       = !v_out_q || m_axis_tready;
	assign rdy_s2        = !v_s2 || rdy_out;
	assign rdy_s1        = !v_s1 || rdy_s2;
	assign adv1          = v_s1 && rdy_s2;
	assign s_axis_tready = rdy_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= s_axis_tvalid;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_out)
				v_out_q <= v_s2;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && rdy_s1) begin
			kind_s1  <= s_axis_tuser;
			addr_s1  <= s_axis_tdata[15:0];
			wdata_s1 <= s_axis_tdata[31:16];
		end
	end

	mmad_decode u_decode (
		.kind       (kind_s1),
		.address    (addr_s1),
		.write_data (wdata_s1),
		.mode       (ctl_q[MODE_BIT]),
		.dec        (dec)
	);

	// set/clear control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_q <= '0;
		else if (adv1 && dec.ctl_we)
			ctl_q[dec.ctl_idx] <= dec.ctl_set;
	end

	mmad_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BANK_DEPTH)
	) u_even_bank (
		.clk   (clk),
		.en    (adv1),
		.we    (dec.even_we),
		.addr  (dec.even_addr),
		.wdata (dec.even_wdata),
		.rdata (even_rd)
	);

	mmad_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BANK_DEPTH)
	) u_odd_bank (
		.clk   (clk),
		.en    (adv1),
		.we    (dec.odd_we),
		.addr  (dec.odd_addr),
		.wdata (dec.odd_wdata),
		.rdata (odd_rd)
	);

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv1) begin
			route_s2  <= dec.route;
			target_s2 <= dec.target;
			rsel_s2   <= dec.rsel;
			swap_s2   <= dec.swap;
			ctlbit_s2 <= ctl_q[dec.ctl_idx];
		end
	end

	// assemble read data from the bank lanes
	assign hi_byte = swap_s2 ? odd_rd : even_rd;
	assign lo_byte = swap_s2 ? even_rd : odd_rd;

	always_comb begin
		case (rsel_s2)
			RSEL_CTL:  rdata_s2 = {{(DATA_W-1){1'b0}}, ctlbit_s2};
			RSEL_BYTE: rdata_s2 = {{BYTE_W{1'b0}}, hi_byte};
			RSEL_WORD: rdata_s2 = {hi_byte, lo_byte};
			default:   rdata_s2 = '0;
		endcase
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (v_s2 && rdy_out) begin
			route_q  <= route_s2;
			target_q <= target_s2;
			rdata_q  <= rdata_s2;
		end
	end

	assign m_axis_tvalid = v_out_q;
	assign m_axis_tdata  = {target_q, rdata_q};
	assign m_axis_tuser  = route_q;

	// a transaction that writes both banks is a memory word write
	`MMAD_ASSERT_IMPLY(a_both_banks_mem, clk, arst_n, adv1 && dec.even_we && dec.odd_we, dec.route == ROUTE_MEM && dec.rsel == RSEL_ZERO)

	// control set lands in the chosen bit
	`MMAD_ASSERT_NEXT(a_ctl_set, clk, arst_n, adv1 && dec.ctl_we && dec.ctl_set, ctl_q[$past(dec.ctl_idx)])

	// errors and forwarded transactions read as zero
	`MMAD_ASSERT_IMPLY(a_err_zero, clk, arst_n, v_out_q && (route_q == ROUTE_ERR || route_q == ROUTE_FWD), rdata_q == '0)

	// control reads carry a single bit
	`MMAD_ASSERT_IMPLY(a_ctl_narrow, clk, arst_n, v_out_q && route_q == ROUTE_CTL, rdata_q[DATA_W-1:1] == '0)

endmodule

@@ verif/memory_map_access_decoder_top_tb.sv @@
// self-checking testbench for the memory map access decoder top level
// depends on mmad_pkg and memory_map_access_decoder_top with its submodules
`timescale 1ns / 1ps

module memory_map_access_decoder_top_tb;
	import mmad_pkg::*;

	localparam int unsigned RAND_PER_PHASE = 350;
	localparam int unsigned HOLD_CYCLES    = 120;
	localparam int unsigned DRAIN_CYCLES   = 20;
	localparam int unsigned MAX_REPORTS    = 10;
	localparam int unsigned POOL_DEPTH     = 64;
	localparam int unsigned TIMEOUT_NS     = 2000000;

	typedef enum logic [1:0] {
		KIND_RD_BYTE = 2'd0,
		KIND_WR_BYTE = 2'd1,
		KIND_RD_WORD = 2'd2,
		KIND_WR_WORD = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		TRAFFIC_CALM,
		TRAFFIC_SRC_IDLE,
		TRAFFIC_SNK_STALL,
		TRAFFIC_BOTH,
		TRAFFIC_PRESSURE
	} traffic_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] addr;
		logic [15:0] wdata;
	} access_t;

	typedef struct packed {
		logic [15:0] rdata;
		route_t      route;
		logic [15:0] target;
	} access_result_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;  // [15:0] address, [31:16] write_data
	logic [1:0]  s_axis_tuser  = '0;  // [1:0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [15:0] read_data, [31:16] target_address
	logic [1:0]  m_axis_tuser;        // [1:0] route

	// mirrored state of the decoder
	logic [7:0]  mem_image [0:65535];
	bit          mem_known [0:65535];
	logic [15:0] ctl_image = '0;

	access_t        pending_accesses [$];
	access_result_t expected_results [$];
	logic [15:0]    written_addrs [$];
	access_t        drive_acc;
	access_result_t want;
	traffic_t       traffic = TRAFFIC_CALM;
	int unsigned    hold_count;
	int unsigned    mismatch_count = 0;

	memory_map_access_decoder_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// region of an address before any redirection
	function automatic region_t area_of(input logic [15:0] a);
		if (a <= MEM_TOP)
			return REGION_MEM;
		if (a[7:0] <= 8'h03)
			return REGION_PER;
		if (a[7:0] <= 8'h1F)
			return REGION_DED;
		if (a[7:0] <= 8'h23)
			return REGION_PER;
		if (a[7:0] <= 8'hBF)
			return REGION_DED;
		if (a[7:0] <= 8'hDF)
			return REGION_CTL;
		return REGION_DED;
	endfunction

	// mirror of a top-page offset while the mode bit is clear
	function automatic logic [7:0] mirror_of(input logic [7:0] off);
		case (off[7:5])
			3'd0: return {6'h00, off[1:0]};
			3'd1: return {6'h08, off[1:0]};
			3'd2: return off[3] ? {6'h12, off[1:0]} : 8'h40;
			default: return off;
		endcase
	endfunction

	// final address and region after vector and mirror redirection
	function automatic void resolve(input logic [15:0] a, output logic [15:0] tgt,
			output region_t area);
		tgt = a;
		area = area_of(a);
		if (area == REGION_DED) begin
			if (a >= VEC_BASE)
				tgt = a - VEC_SHIFT;
			else if (!ctl_image[MODE_BIT])
				tgt = {PAGE_HI, mirror_of(a[7:0])};
			area = area_of(tgt);
			// a target that is still dedicated (a fold fixed point, or any with mode set) falls through to memory
			if (area == REGION_DED)
				area = REGION_MEM;
		end
	endfunction

	// true when a read would touch a memory byte never written
	function automatic bit reads_unknown(input access_t acc);
		logic [15:0] tgt;
		region_t     area;
		resolve(acc.addr, tgt, area);
		if (acc.kind[KIND_WRITE_BIT] || area != REGION_MEM)
			return 1'b0;
		if (!mem_known[tgt])
			return 1'b1;
		return acc.kind[KIND_WORD_BIT] && !mem_known[16'(tgt + 16'd1)];
	endfunction

	// expected result of one transaction, updating the mirrored state
	function automatic access_result_t predict_access(input access_t acc);
		access_result_t res;
		region_t        area;
		logic [15:0]    tgt;
		logic [15:0]    nxt;
		logic           is_wr;
		logic           is_word;
		is_wr   = acc.kind[KIND_WRITE_BIT];
		is_word = acc.kind[KIND_WORD_BIT];
		resolve(acc.addr, tgt, area);
		nxt        = tgt + 16'd1;
		res.rdata  = '0;
		res.target = tgt;
		res.route  = ROUTE_MEM;
		if (area == REGION_PER) begin
			if (is_word)
				res.route = ROUTE_ERR;
			else
				res.route = ROUTE_FWD;
		end else if (area == REGION_CTL) begin
			if (is_word) begin
				res.route = ROUTE_ERR;
			end else begin
				res.route = ROUTE_CTL;
				// odd address sets, even clears; write data plays no part
				if (is_wr)
					ctl_image[tgt[4:1]] = tgt[0];
				else
					res.rdata = {15'd0, ctl_image[tgt[4:1]]};
			end
		end else if (is_wr) begin
			if (is_word) begin
				mem_image[tgt] = acc.wdata[15:8];
				mem_image[nxt] = acc.wdata[7:0];
				mem_known[tgt] = 1'b1;
				mem_known[nxt] = 1'b1;
			end else begin
				mem_image[tgt] = acc.wdata[7:0];
				mem_known[tgt] = 1'b1;
			end
		end else if (is_word) begin
			res.rdata = {mem_image[tgt], mem_image[nxt]};
		end else begin
			res.rdata = {8'd0, mem_image[tgt]};
		end
		return res;
	endfunction

	// queue one transaction and its expected result; unsafe reads become writes
	task automatic queue_access(input kind_t kind, input logic [15:0] addr,
			input logic [15:0] wdata);
		access_t        acc;
		access_result_t res;
		acc.kind  = kind;
		acc.addr  = addr;
		acc.wdata = wdata;
		if (reads_unknown(acc))
			acc.kind = kind_t'({acc.kind[KIND_WORD_BIT], 1'b1});
		res = predict_access(acc);
		pending_accesses.push_back(acc);
		expected_results.push_back(res);
		// remember written memory addresses so later reads hit them
		if (acc.kind[KIND_WRITE_BIT] && res.route == ROUTE_MEM) begin
			written_addrs.push_back(acc.addr);
			if (written_addrs.size() > POOL_DEPTH)
				void'(written_addrs.pop_front());
		end
	endtask

	// one random transaction, weighted toward reuse and the top page
	task automatic queue_random_access();
		logic [15:0] addr;
		kind_t       kind;
		kind = kind_t'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				if (written_addrs.size() != 0)
					addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
				else
					addr = 16'h0000;
				if ($urandom_range(0, 9) < 7)
					kind = $urandom_range(0, 1) ? KIND_RD_WORD : KIND_RD_BYTE;
			end
			3: addr = 16'($urandom());
			4: addr = 16'($urandom_range(0, 63));
			5: addr = 16'hFF00 + 16'($urandom_range(0, 35));
			6: begin
				// bias toward the mode bit so the fold is switched often
				if ($urandom_range(0, 1))
					addr = 16'hFFDE + 16'($urandom_range(0, 1));
				else
					addr = 16'hFFC0 + 16'($urandom_range(0, 31));
			end
			7, 8: addr = {PAGE_HI, 8'($urandom())};
			default: begin
				case ($urandom_range(0, 5))
					0: addr = 16'h0000;
					1: addr = 16'hFEFF;
					2: addr = 16'hFF03;
					3: addr = 16'hFFF1;
					4: addr = 16'hFFF2;
					default: addr = 16'hFFFF;
				endcase
			end
		endcase
		queue_access(kind, addr, 16'($urandom()));
	endtask

	function automatic bit sender_pauses();
		if (traffic == TRAFFIC_SRC_IDLE)
			return $urandom_range(0, 99) < 72;
		if (traffic == TRAFFIC_BOTH)
			return $urandom_range(0, 99) < 30;
		return 1'b0;
	endfunction

	function automatic bit receiver_stalls();
		if (traffic == TRAFFIC_SNK_STALL)
			return $urandom_range(0, 99) < 72;
		if (traffic == TRAFFIC_BOTH)
			return $urandom_range(0, 99) < 30;
		return 1'b0;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endtask

	// driver: offer the next pending transaction once the previous one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_accesses.size() != 0 && !sender_pauses()) begin
				drive_acc = pending_accesses.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {drive_acc.wdata, drive_acc.addr};
				s_axis_tuser  <= drive_acc.kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off in the pressure phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_count    <= 0;
		end else if (traffic == TRAFFIC_PRESSURE && hold_count < HOLD_CYCLES) begin
			m_axis_tready <= 1'b0;
			hold_count    <= hold_count + 1;
		end else begin
			m_axis_tready <= !receiver_stalls();
		end
	end

	// monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result rdata=%h route=%0d target=%h",
					m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[31:16]));
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[15:0] !== want.rdata || m_axis_tuser !== want.route ||
						m_axis_tdata[31:16] !== want.target)
					note_mismatch($sformatf(
						"expected rdata=%h route=%0d target=%h, got rdata=%h route=%0d target=%h",
						want.rdata, want.route, want.target,
						m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[31:16]));
			end
		end
	end

	// stimulus: directed transactions, then random phases with different idling
	initial begin : stimulus
		traffic_t plan [5];
		plan = '{TRAFFIC_CALM, TRAFFIC_SRC_IDLE, TRAFFIC_SNK_STALL, TRAFFIC_BOTH,
			TRAFFIC_PRESSURE};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// data extremes and big-endian word order
		queue_access(KIND_WR_WORD, 16'h0000, 16'hFFFF);
		queue_access(KIND_RD_WORD, 16'h0000, 16'h0000);
		queue_access(KIND_WR_BYTE, 16'h0001, 16'h0000);
		queue_access(KIND_RD_WORD, 16'h0000, 16'hFFFF);
		// word at the top of memory reaches into the next page
		queue_access(KIND_WR_WORD, 16'hFEFF, 16'h1234);
		queue_access(KIND_RD_WORD, 16'hFEFF, 16'h0000);
		// vector area moves down, word wraps from BFFF to C000
		queue_access(KIND_WR_WORD, 16'hFFFF, 16'hBEEF);
		queue_access(KIND_RD_WORD, 16'hFFFF, 16'h0000);
		queue_access(KIND_WR_BYTE, 16'hFFF2, 16'h00A5);
		queue_access(KIND_RD_BYTE, 16'hFFF2, 16'h0000);
		// peripheral forwarding and word errors
		queue_access(KIND_RD_BYTE, 16'hFF00, 16'h0000);
		queue_access(KIND_WR_BYTE, 16'hFF23, 16'hFFFF);
		queue_access(KIND_WR_WORD, 16'hFF20, 16'h5555);
		queue_access(KIND_RD_WORD, 16'hFFC0, 16'h0000);
		queue_access(KIND_RD_BYTE, 16'hFFDF, 16'h0000);
		// mode clear: dedicated addresses fold onto mirrors
		queue_access(KIND_WR_BYTE, 16'hFF04, 16'h0077);
		queue_access(KIND_RD_WORD, 16'hFF3F, 16'h0000);
		queue_access(KIND_WR_BYTE, 16'hFF57, 16'h0011);
		queue_access(KIND_RD_BYTE, 16'hFF40, 16'h0000);
		queue_access(KIND_WR_WORD, 16'hFF5E, 16'hC3C3);
		queue_access(KIND_RD_WORD, 16'hFF4E, 16'h0000);
		// mode set by an odd control address, data ignored
		queue_access(KIND_WR_BYTE, 16'hFFDF, 16'h0000);
		queue_access(KIND_WR_BYTE, 16'hFF04, 16'h0099);
		queue_access(KIND_RD_BYTE, 16'hFFDE, 16'h0000);
		queue_access(KIND_WR_BYTE, 16'hFFDE, 16'hFFFF);

		foreach (plan[p]) begin
			while (pending_accesses.size() != 0)
				@(negedge clk);
			traffic = plan[p];
			repeat (RAND_PER_PHASE)
				queue_random_access();
		end

		while (pending_accesses.size() != 0 || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("status: fail");
		$finish;
	end

endmodule

@@ memory_map_access_decoder_top.f @@
+incdir+rtl
rtl/mmad_pkg.sv
rtl/mmad_ram.sv
rtl/mmad_decode.sv
rtl/memory_map_access_decoder_top.sv
verif/memory_map_access_decoder_top_tb.sv
